>>> src/llqm_pkg.sv
package llqm_pkg;

  // default number of item slots in the pool
  localparam int POOL_SIZE = 1024;

  // payload field widths
  localparam int REQ_W = 3;
  localparam int INDEX_W = 11;
  localparam int STATUS_W = 2;
  localparam int RESULT_W = 10;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_INS_HEAD  = 3'd1,
    REQ_INS_AFTER = 3'd2,
    REQ_TAKE      = 3'd3,
    REQ_DELETE    = 3'd4,
    REQ_PEEK      = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

endpackage

>>> src/llqm_req_if.sv
interface llqm_req_if;
  import llqm_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [INDEX_W-1:0] item_index;
  logic [INDEX_W-1:0] prev_index;

  modport source (output valid, output req_type, output item_index, output prev_index,
                  input ready);
  modport sink (input valid, input req_type, input item_index, input prev_index,
                output ready);
endinterface

>>> src/llqm_rsp_if.sv
interface llqm_rsp_if;
  import llqm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RESULT_W-1:0] result_index;
  logic                queue_empty;

  modport source (output valid, output status, output result_index, output queue_empty,
                  input ready);
  modport sink (input valid, input status, input result_index, input queue_empty,
                output ready);
endinterface

>>> src/linked_list_queue_manager_core.sv
// Singly linked queue over a pool of PoolSize item slots. The next-pointer table lives in
// one synchronous RAM (one write port, one read port, registered read data); head and
// tail are registers, and the value PoolSize marks an empty link. One request is worked
// at a time and its result goes to an output register, so a new request is taken while
// the last result still waits. Peek, invalid index, empty queue, unused codes and insert
// at head read no link; append writes the item's link and, on a non-empty queue, then
// links the old tail to it; take and delete of the head read the head's link; insert
// after reads the link of prev_index, then writes the item and prev_index; delete of any
// other member walks the chain from the head to find its predecessor, giving up at an
// empty link or after PoolSize links. Every link read waits for the registered RAM data,
// and two link writes of one request go out in separate cycles. The table is not cleared
// after reset; insert after reads the link of prev_index even if no request wrote it.
module linked_list_queue_manager_core #(
  parameter int PoolSize = llqm_pkg::POOL_SIZE
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  llqm_req_if.sink   req_i,
  llqm_rsp_if.source rsp_o
);
  import llqm_pkg::*;

  localparam int IdxW = $clog2(PoolSize);
  localparam int LinkW = $clog2(PoolSize + 1);
  localparam int CmpW = (LinkW > INDEX_W) ? LinkW : INDEX_W;
  localparam logic [LinkW-1:0] NullLink = LinkW'(PoolSize);
  localparam logic [CmpW-1:0] NullCmp = CmpW'(PoolSize);

  typedef enum logic [2:0] {
    S_IDLE,
    S_IA_RD,
    S_HD_RD,
    S_WALK,
    S_DL_RD,
    S_WR2,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [LinkW-1:0] head_q, head_d, tail_q, tail_d;
  logic [LinkW-1:0] item_q, item_d, prev_q, prev_d, p_q, p_d, cnt_q, cnt_d;
  logic [LinkW-1:0] wa2_q, wa2_d, wd2_q, wd2_d;
  status_e stat_q, stat_d;
  logic [RESULT_W-1:0] res_q, res_d;
  logic rsp_valid_q, rsp_valid_d;
  status_e rsp_status_q, rsp_status_d;
  logic [RESULT_W-1:0] rsp_res_q, rsp_res_d;
  logic rsp_empty_q, rsp_empty_d;

  logic ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [LinkW-1:0] ram_wdata, ram_rdata;

  logic [CmpW-1:0] item_ext, prev_ext, head_ext;
  logic item_bad, prev_bad, head_null, tail_null, rdata_null;
  req_e req_code;

  function automatic logic [LinkW-1:0] norm_link(input logic [LinkW-1:0] v);
    return (v >= NullLink) ? NullLink : v;
  endfunction

  llqm_ram #(
    .Width(LinkW),
    .Depth(PoolSize)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign item_ext = CmpW'(req_i.item_index);
  assign prev_ext = CmpW'(req_i.prev_index);
  assign head_ext = CmpW'(head_q);
  assign item_bad = item_ext >= NullCmp;
  assign prev_bad = prev_ext >= NullCmp;
  assign head_null = head_q >= NullLink;
  assign tail_null = tail_q >= NullLink;
  assign rdata_null = ram_rdata >= NullLink;
  assign req_code = req_e'(req_i.req_type);

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.result_index = rsp_res_q;
  assign rsp_o.queue_empty = rsp_empty_q;

  always_comb begin
    state_d = state_q;
    head_d = head_q;
    tail_d = tail_q;
    item_d = item_q;
    prev_d = prev_q;
    p_d = p_q;
    cnt_d = cnt_q;
    wa2_d = wa2_q;
    wd2_d = wd2_q;
    stat_d = stat_q;
    res_d = res_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_res_d = rsp_res_q;
    rsp_empty_d = rsp_empty_q;
    ram_we = 1'b0;
    ram_waddr = wa2_q[IdxW-1:0];
    ram_wdata = wd2_q;
    ram_raddr = p_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          item_d = item_ext[LinkW-1:0];
          prev_d = prev_ext[LinkW-1:0];
          stat_d = ST_OK;
          res_d = '0;
          state_d = S_DONE;
          case (req_code)
            REQ_APPEND: begin
              if (item_bad) begin
                stat_d = ST_INVALID;
              end else begin
                ram_we = 1'b1;
                ram_waddr = item_ext[IdxW-1:0];
                ram_wdata = NullLink;
                tail_d = item_ext[LinkW-1:0];
                if (tail_null) begin
                  head_d = item_ext[LinkW-1:0];
                end else begin
                  // old tail gets linked to the new item next cycle
                  wa2_d = tail_q;
                  wd2_d = item_ext[LinkW-1:0];
                  state_d = S_WR2;
                end
              end
            end
            REQ_INS_HEAD: begin
              if (item_bad) begin
                stat_d = ST_INVALID;
              end else begin
                ram_we = 1'b1;
                ram_waddr = item_ext[IdxW-1:0];
                ram_wdata = head_q;
                if (head_null) begin
                  tail_d = item_ext[LinkW-1:0];
                end
                head_d = item_ext[LinkW-1:0];
              end
            end
            REQ_INS_AFTER: begin
              if (item_bad || prev_bad) begin
                stat_d = ST_INVALID;
              end else begin
                ram_raddr = prev_ext[IdxW-1:0];
                state_d = S_IA_RD;
              end
            end
            REQ_TAKE: begin
              if (head_null) begin
                stat_d = ST_EMPTY;
              end else begin
                res_d = head_ext[RESULT_W-1:0];
                item_d = head_q;
                ram_raddr = head_q[IdxW-1:0];
                state_d = S_HD_RD;
              end
            end
            REQ_DELETE: begin
              if (item_bad) begin
                stat_d = ST_INVALID;
              end else if (head_null) begin
                stat_d = ST_NOT_FOUND;
              end else if (item_ext[LinkW-1:0] == head_q) begin
                ram_raddr = head_q[IdxW-1:0];
                state_d = S_HD_RD;
              end else begin
                // predecessor search starts at the head
                p_d = head_q;
                cnt_d = LinkW'(1);
                ram_raddr = head_q[IdxW-1:0];
                state_d = S_WALK;
              end
            end
            REQ_PEEK: begin
              if (head_null) begin
                stat_d = ST_EMPTY;
              end else begin
                res_d = head_ext[RESULT_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_IA_RD: begin
        ram_we = 1'b1;
        ram_waddr = item_q[IdxW-1:0];
        ram_wdata = norm_link(ram_rdata);
        wa2_d = prev_q;
        wd2_d = item_q;
        if (prev_q == tail_q) begin
          tail_d = item_q;
        end
        state_d = S_WR2;
      end
      S_HD_RD: begin
        head_d = norm_link(ram_rdata);
        ram_we = 1'b1;
        ram_waddr = item_q[IdxW-1:0];
        ram_wdata = NullLink;
        if (rdata_null) begin
          tail_d = NullLink;
        end
        state_d = S_DONE;
      end
      S_WALK: begin
        if (ram_rdata == item_q) begin
          // p_q is the predecessor, fetch the link of the item itself
          ram_raddr = item_q[IdxW-1:0];
          state_d = S_DL_RD;
        end else if (cnt_q == NullLink || rdata_null) begin
          stat_d = ST_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          p_d = ram_rdata;
          ram_raddr = ram_rdata[IdxW-1:0];
          cnt_d = cnt_q + LinkW'(1);
        end
      end
      S_DL_RD: begin
        ram_we = 1'b1;
        ram_waddr = p_q[IdxW-1:0];
        ram_wdata = norm_link(ram_rdata);
        wa2_d = item_q;
        wd2_d = NullLink;
        if (item_q == tail_q) begin
          tail_d = p_q;
        end
        state_d = S_WR2;
      end
      S_WR2: begin
        ram_we = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_status_d = stat_q;
          rsp_res_d = res_q;
          rsp_empty_d = head_null;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= NullLink;
      tail_q <= NullLink;
      item_q <= '0;
      prev_q <= '0;
      p_q <= '0;
      cnt_q <= '0;
      wa2_q <= '0;
      wd2_q <= '0;
      stat_q <= ST_OK;
      res_q <= '0;
      rsp_valid_q <= 1'b0;
      rsp_status_q <= ST_OK;
      rsp_res_q <= '0;
      rsp_empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      tail_q <= tail_d;
      item_q <= item_d;
      prev_q <= prev_d;
      p_q <= p_d;
      cnt_q <= cnt_d;
      wa2_q <= wa2_d;
      wd2_q <= wd2_d;
      stat_q <= stat_d;
      res_q <= res_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_status_q <= rsp_status_d;
      rsp_res_q <= rsp_res_d;
      rsp_empty_q <= rsp_empty_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !req_i.valid) |-> !ram_we)
    else $error("link table written while no request in flight");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != S_IDLE))
    else $error("accepted request produced no work");

  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (head_null == tail_null))
    else $error("head and tail disagree on queue empty");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside of completion");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (cnt_q != '0 && cnt_q <= NullLink))
    else $error("predecessor walk count out of range");
`endif

endmodule

>>> src/llqm_ram.sv
module llqm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
